>>> rtl/core/mcs_pkg.sv
package mcs_pkg;

  localparam int NUM_STATES  = 32;
  localparam int WEIGHT_BITS = 16;

  // widths of the ports fixed by the item fields
  localparam int OP_W      = 2;
  localparam int IN_WGT_W  = 16;
  localparam int VALUE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int STATUS_W  = 2;

  localparam int IDX_W     = $clog2(NUM_STATES);
  localparam int CNT_W     = $clog2(NUM_STATES + 1);
  localparam int WADDR_W   = 2 * IDX_W;
  localparam int W_DEPTH   = NUM_STATES * NUM_STATES;
  localparam int TOTAL_W   = WEIGHT_BITS + IDX_W;
  localparam int THR_W     = TOTAL_W + FRAC_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [OP_W-1:0] OP_WR_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_VALUE  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP      = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACK  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USED  = 2'd1;

  typedef struct packed {
    logic [IDX_W-1:0] start_state;
    logic [CNT_W-1:0] states_in_use;
  } mcs_cfg_t;

  typedef struct packed {
    logic                   w_we;
    logic [WADDR_W-1:0]     w_waddr;
    logic [WEIGHT_BITS-1:0] w_wdata;
    logic [WADDR_W-1:0]     w_raddr;
    logic                   t_we;
    logic [IDX_W-1:0]       t_waddr;
    logic [TOTAL_W-1:0]     t_wdata;
    logic [IDX_W-1:0]       t_raddr;
    logic                   v_we;
    logic [IDX_W-1:0]       v_waddr;
    logic [VALUE_W-1:0]     v_wdata;
    logic [IDX_W-1:0]       v_raddr;
  } mcs_mem_req_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [TOTAL_W-1:0]     t_rdata;
    logic [VALUE_W-1:0]     v_rdata;
  } mcs_mem_rsp_t;

endpackage

>>> rtl/core/mcs_ram.sv
module mcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/mcs_ctrl.sv
module mcs_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcs_pkg::OP_W-1:0]        in_operation,
  input  logic [mcs_pkg::IDX_W-1:0]       in_from_index,
  input  logic [mcs_pkg::IDX_W-1:0]       in_to_index,
  input  logic [mcs_pkg::IN_WGT_W-1:0]    in_weight,
  input  logic [mcs_pkg::VALUE_W-1:0]     in_value_in,
  input  logic [mcs_pkg::FRAC_W-1:0]      in_uniform_draw,
  input  mcs_pkg::mcs_cfg_t               cfg,
  output mcs_pkg::mcs_mem_req_t           mem_req,
  input  mcs_pkg::mcs_mem_rsp_t           mem_rsp,
  output logic                            out_valid,
  output logic [mcs_pkg::IDX_W-1:0]       out_state_index,
  output logic [mcs_pkg::VALUE_W-1:0]     out_state_value,
  output logic [mcs_pkg::STATUS_W-1:0]    out_status
);
  import mcs_pkg::*;

  localparam int SW = 3;
  localparam logic [SW-1:0] S_CLEAR = 3'd0;
  localparam logic [SW-1:0] S_IDLE  = 3'd1;
  localparam logic [SW-1:0] S_WWR   = 3'd2;
  localparam logic [SW-1:0] S_SUM   = 3'd3;
  localparam logic [SW-1:0] S_THR   = 3'd4;
  localparam logic [SW-1:0] S_SRCH  = 3'd5;
  localparam logic [SW-1:0] S_VRD   = 3'd6;
  localparam logic [SW-1:0] S_VOUT  = 3'd7;

  logic [SW-1:0]          state_r, state_nxt;
  logic [WADDR_W-1:0]     clr_r, clr_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic [IDX_W-1:0]       from_r, from_nxt;
  logic [IDX_W-1:0]       to_r, to_nxt;
  logic [WEIGHT_BITS-1:0] weight_r, weight_nxt;
  logic [FRAC_W-1:0]      draw_r, draw_nxt;
  logic [IDX_W-1:0]       col_r, col_nxt;
  logic [TOTAL_W-1:0]     acc_r, acc_nxt;
  logic [THR_W-1:0]       thr_r, thr_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       out_index_r, out_index_nxt;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;

  logic                   accept;
  logic [CNT_W-1:0]       used_n;
  logic [IDX_W-1:0]       last_col;
  logic                   full;
  logic                   from_ok, to_ok;
  logic [IDX_W-1:0]       start_sat;
  logic [TOTAL_W-1:0]     total_src;
  logic [TOTAL_W-1:0]     cum_nxt;
  logic [THR_W-1:0]       cum_sh;
  logic [THR_W-1:0]       prod;
  logic                   hit;
  logic [IDX_W-1:0]       col_inc;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // clamp the sampling range to [2, NUM_STATES]
  always_comb begin
    if (cfg.states_in_use < CNT_W'(2)) begin
      used_n = CNT_W'(2);
    end else if (cfg.states_in_use > CNT_W'(NUM_STATES)) begin
      used_n = CNT_W'(NUM_STATES);
    end else begin
      used_n = cfg.states_in_use;
    end
  end

  assign last_col  = IDX_W'(used_n - CNT_W'(1));
  assign full      = (used_n == CNT_W'(NUM_STATES));
  assign from_ok   = ({1'b0, in_from_index} < CNT_W'(NUM_STATES));
  assign to_ok     = ({1'b0, in_to_index} < CNT_W'(NUM_STATES));
  assign start_sat = ({1'b0, cfg.start_state} < CNT_W'(NUM_STATES)) ?
                     cfg.start_state : IDX_W'(NUM_STATES - 1);

  // the stored row total only covers the full row
  assign total_src = full ? mem_rsp.t_rdata : acc_r;
  assign cum_nxt   = acc_r + TOTAL_W'(mem_rsp.w_rdata);
  assign cum_sh    = {cum_nxt, FRAC_W'(0)};
  assign prod      = THR_W'(draw_r) * THR_W'(total_src);
  assign hit       = (cum_sh > thr_r);
  assign col_inc   = col_r + IDX_W'(1);

  always_comb begin
    mem_req.w_we    = 1'b0;
    mem_req.w_waddr = {from_r, to_r};
    mem_req.w_wdata = weight_r;
    mem_req.w_raddr = {cur_r, IDX_W'(0)};
    mem_req.t_we    = 1'b0;
    mem_req.t_waddr = from_r;
    mem_req.t_wdata = mem_rsp.t_rdata - TOTAL_W'(mem_rsp.w_rdata) + TOTAL_W'(weight_r);
    mem_req.t_raddr = cur_r;
    mem_req.v_we    = 1'b0;
    mem_req.v_waddr = in_from_index;
    mem_req.v_wdata = in_value_in;
    mem_req.v_raddr = cur_r;

    case (state_r)
      S_CLEAR: begin
        mem_req.w_we    = 1'b1;
        mem_req.w_waddr = clr_r;
        mem_req.w_wdata = '0;
        mem_req.t_we    = 1'b1;
        mem_req.t_waddr = clr_r[IDX_W-1:0];
        mem_req.t_wdata = '0;
        mem_req.v_we    = 1'b1;
        mem_req.v_waddr = clr_r[IDX_W-1:0];
        mem_req.v_wdata = '0;
      end
      S_IDLE: begin
        if (accept && in_operation == OP_WR_WEIGHT) begin
          mem_req.w_raddr = {in_from_index, in_to_index};
          mem_req.t_raddr = in_from_index;
        end
        mem_req.v_we = accept && (in_operation == OP_WR_VALUE) && from_ok;
      end
      S_WWR: begin
        mem_req.w_we = 1'b1;
        mem_req.t_we = 1'b1;
      end
      S_SUM, S_SRCH: begin
        mem_req.w_raddr = {cur_r, col_inc};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    weight_nxt     = weight_r;
    draw_nxt       = draw_r;
    col_nxt        = col_r;
    acc_nxt        = acc_r;
    thr_nxt        = thr_r;
    status_nxt     = status_r;
    out_valid_nxt  = 1'b0;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + WADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          from_nxt   = in_from_index;
          to_nxt     = in_to_index;
          weight_nxt = in_weight[WEIGHT_BITS-1:0];
          draw_nxt   = in_uniform_draw;
          status_nxt = ST_ACK;
          col_nxt    = '0;
          acc_nxt    = '0;
          case (in_operation)
            OP_WR_WEIGHT: state_nxt = (from_ok && to_ok) ? S_WWR : S_VRD;
            OP_WR_VALUE:  state_nxt = S_VRD;
            OP_STEP:      state_nxt = full ? S_THR : S_SUM;
            default: begin
              cur_nxt   = start_sat;
              state_nxt = S_VRD;
            end
          endcase
        end
      end
      S_WWR: begin
        state_nxt = S_VRD;
      end
      S_SUM: begin
        acc_nxt = cum_nxt;
        col_nxt = col_inc;
        if (col_r == last_col) begin
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        thr_nxt = prod;
        acc_nxt = '0;
        col_nxt = '0;
        if (total_src == '0) begin
          // hold the state on an empty row
          status_nxt = ST_ZERO;
          state_nxt  = S_VRD;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        acc_nxt = cum_nxt;
        col_nxt = col_inc;
        // the last used column always closes the search
        if (hit || col_r == last_col) begin
          cur_nxt    = col_r;
          status_nxt = ST_DONE;
          state_nxt  = S_VRD;
        end
      end
      S_VRD: begin
        state_nxt = S_VOUT;
      end
      S_VOUT: begin
        out_valid_nxt  = 1'b1;
        out_index_nxt  = cur_r;
        out_value_nxt  = mem_rsp.v_rdata;
        out_status_nxt = status_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    weight_r     <= weight_nxt;
    draw_r       <= draw_nxt;
    col_r        <= col_nxt;
    acc_r        <= acc_nxt;
    thr_r        <= thr_nxt;
    status_r     <= status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_state_index = out_index_r;
  assign out_state_value = out_value_r;
  assign out_status      = out_status_r;

endmodule

>>> rtl/core/markov_chain_state_sampler.sv
// After accept, a value write or restart goes to the value read and the result strobe;
// a weight write first writes the weight and the row total; a step on an empty row
// stops at the row total check, else it walks the weight memory to the picked column,
// one read per cycle, first summing the row if states_in_use (clamped to 2..32) < 32.
// A new word is taken in the cycle the result strobe is up; the receiver cannot stall.
// Sync reset clears the control registers and zeroes all 1024 weight words, busy held high.
module markov_chain_state_sampler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mcs_pkg::OP_W-1:0]         in_operation,
  input  logic [mcs_pkg::IDX_W-1:0]        in_from_index,
  input  logic [mcs_pkg::IDX_W-1:0]        in_to_index,
  input  logic [mcs_pkg::IN_WGT_W-1:0]     in_weight,
  input  logic [mcs_pkg::VALUE_W-1:0]      in_value_in,
  input  logic [mcs_pkg::FRAC_W-1:0]       in_uniform_draw,
  output logic                             out_valid,
  output logic [mcs_pkg::IDX_W-1:0]        out_state_index,
  output logic [mcs_pkg::VALUE_W-1:0]      out_state_value,
  output logic [mcs_pkg::STATUS_W-1:0]     out_status,
  input  logic                             cfg_we,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mcs_pkg::*;

  logic [IDX_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  mcs_cfg_t         cfg;
  mcs_mem_req_t     mem_req;
  mcs_mem_rsp_t     mem_rsp;

  always_comb begin
    start_nxt = start_r;
    used_nxt  = used_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START: start_nxt = cfg_data[IDX_W-1:0];
        CFG_USED:  used_nxt  = cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      used_r  <= CNT_W'(NUM_STATES);
    end else begin
      start_r <= start_nxt;
      used_r  <= used_nxt;
    end
  end

  assign cfg.start_state   = start_r;
  assign cfg.states_in_use = used_r;

  mcs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(W_DEPTH)) u_weights (
    .clk   (clk),
    .we    (mem_req.w_we),
    .waddr (mem_req.w_waddr),
    .wdata (mem_req.w_wdata),
    .raddr (mem_req.w_raddr),
    .rdata (mem_rsp.w_rdata)
  );

  mcs_ram #(.WIDTH(TOTAL_W), .DEPTH(NUM_STATES)) u_totals (
    .clk   (clk),
    .we    (mem_req.t_we),
    .waddr (mem_req.t_waddr),
    .wdata (mem_req.t_wdata),
    .raddr (mem_req.t_raddr),
    .rdata (mem_rsp.t_rdata)
  );

  mcs_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_STATES)) u_values (
    .clk   (clk),
    .we    (mem_req.v_we),
    .waddr (mem_req.v_waddr),
    .wdata (mem_req.v_wdata),
    .raddr (mem_req.v_raddr),
    .rdata (mem_rsp.v_rdata)
  );

  mcs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_from_index   (in_from_index),
    .in_to_index     (in_to_index),
    .in_weight       (in_weight),
    .in_value_in     (in_value_in),
    .in_uniform_draw (in_uniform_draw),
    .cfg             (cfg),
    .mem_req         (mem_req),
    .mem_rsp         (mem_rsp),
    .out_valid       (out_valid),
    .out_state_index (out_state_index),
    .out_state_value (out_state_value),
    .out_status      (out_status)
  );

endmodule

>>> rtl/core/mcs_checker.sv
module mcs_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [mcs_pkg::STATUS_W-1:0]     out_status
);
  import mcs_pkg::*;

  // a result leaves the block idle and ready for the next word
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_ACK ||
                   out_status == ST_ZERO))
    else $error("undefined status code");

endmodule

bind markov_chain_state_sampler mcs_props u_mcs_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status)
);
